// File: sv/jcm_pkg.sv
// Shared types and constants for the joystick calibrate-and-map core.
// Holds the sequencer and phase enums, divider request/response structs and
// register reset values. No dependencies.
package jcm_pkg;

    // Widths of the shared divider: dividend and divisor
    localparam int DIV_W = 16;
    localparam int DVS_W = 9;

    // Default averaging length of one calibration phase
    localparam int SAMPLES_PER_PHASE_DEF = 100;

    // Register reset values
    localparam logic [7:0] OUT_LOW_RST    = 8'h9C;   // -100
    localparam logic [7:0] OUT_CENTER_RST = 8'h00;
    localparam logic [6:0] OUT_HIGH_RST   = 7'd100;
    localparam logic [7:0] SETTLE_RST     = 8'd150;

    // Calibrated bound reset values
    localparam logic [7:0] BOUND_LOW_RST  = 8'd0;
    localparam logic [7:0] BOUND_MID_RST  = 8'd128;
    localparam logic [7:0] BOUND_HIGH_RST = 8'd255;

    // Configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_OUT_LOW    = 2'd0;
    localparam cfg_idx_t CFG_OUT_CENTER = 2'd1;
    localparam cfg_idx_t CFG_OUT_HIGH   = 2'd2;
    localparam cfg_idx_t CFG_SETTLE     = 2'd3;

    // Request kind carried in tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_START  = 1'b1;

    // Calibration phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CENTER = 3'd1,
        PH_TOP    = 3'd2,
        PH_BOTTOM = 3'd3,
        PH_RIGHT  = 3'd4,
        PH_LEFT   = 3'd5
    } phase_t;

    // Sequencer state
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALX_GO,
        ST_CALX_WAIT,
        ST_CALY_GO,
        ST_CALY_WAIT,
        ST_FINISH,
        ST_MAP_SETUP,
        ST_MAP_GO,
        ST_MAP_WAIT,
        ST_MAP_END,
        ST_DONE
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: sv/jcm_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on jcm_pkg for widths and the request/response structs.
module jcm_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  jcm_pkg::div_req_t req,
    output jcm_pkg::div_rsp_t rsp
);
    import jcm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   partial;
    logic [DVS_W:0]   trial;
    logic             fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        partial = {rem_reg, quo_reg[DIV_W-1]};
        trial   = partial - {1'b0, dvs_reg};
        fits    = !trial[DVS_W];
    end

    // Control: load on start, count iterations, pulse done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[DVS_W-1:0] : partial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // A done pulse closes exactly one busy period
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished iteration run");

    // A start request finds the divider free
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    // A start request always opens an iteration run
    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("divider not busy after a start request");

endmodule

// File: sv/joystick_calibrate_and_map_core.sv
// Joystick calibrate-and-map core: sequencer, calibration state, mapping.
// Depends on jcm_pkg and the shared divider jcm_div.
//
// Usage:
//   s_ channel: one request per X/Y sample pair; s_tuser selects an ordinary
//   sample or the start of a calibration run (centre, top, bottom, right,
//   left). Each phase skips settle_samples requests, then averages
//   SAMPLES_PER_PHASE of them.
//   m_ channel: one result per request: both mapped positions, the
//   calibrated flag and the current phase.
//   cfg channel: register writes, always ready; write only while idle.
// Sequencing:
//   One request at a time; s_tready is high only while the sequencer idles.
//   A plain request runs per axis through setup, divider start, the divider
//   iterations, done and end; then the result is loaded. A flat input span
//   skips that axis's divider. Closing a phase adds two averaging divisions
//   before the mapping.
// Reset: synchronous, active low; bounds return to 0/128/255, the flag and
//   phase clear and the registers take their reset values.
// Stall: the result waits in an output register; the next request may be
//   accepted meanwhile and finishes once that register has been drained.
module joystick_calibrate_and_map_core #(
    parameter int SAMPLES_PER_PHASE = jcm_pkg::SAMPLES_PER_PHASE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [7:0] x_sample, [15:8] y_sample
    input  logic [0:0]            s_tuser,   // [0] operation
    // Results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] x_position, [15:8] y_position, [16] is_calibrated,
    // [19:17] cal_phase, [23:20] zero
    output logic [23:0]           m_tdata,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  jcm_pkg::cfg_idx_t     cfg_index,
    input  logic [7:0]            cfg_data
);
    import jcm_pkg::*;

    localparam int SUM_W = $clog2(255 * SAMPLES_PER_PHASE + 1);
    localparam int CNT_W = $clog2(255 + SAMPLES_PER_PHASE + 1);
    localparam int CMP_W = CNT_W + 1;

    // Configuration registers
    logic [7:0] out_low_reg;
    logic [7:0] out_center_reg;
    logic [6:0] out_high_reg;
    logic [7:0] settle_reg;

    // Calibration state
    logic [7:0]       x_lower_reg, x_middle_reg, x_upper_reg;
    logic [7:0]       y_lower_reg, y_middle_reg, y_upper_reg;
    logic             done_flag_reg;
    phase_t           phase_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_x_reg, sum_y_reg;

    // Sequencer and working registers
    state_t            state_reg, state_next;
    logic [7:0]        xs_reg, ys_reg;
    logic [7:0]        ax_reg, ay_reg;
    logic              axis_reg;
    logic signed [18:0] prod_reg;
    logic [DVS_W-1:0]  den_mag_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic [7:0]        o_lo_reg;
    logic [7:0]        x_pos_reg, y_pos_reg;
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic s_take;
    logic [CMP_W-1:0] count_inc;
    logic [CMP_W-1:0] settle_end;
    logic             settled;
    logic             phase_end;

    // Mapping datapath
    logic [7:0]        smp, lo_cur, mid_cur, hi_cur, v_lift, v_clamp;
    logic [7:0]        in_lo, in_hi;
    logic signed [9:0] o_lo_w, o_hi_w, span;
    logic signed [8:0] diff, den_cur;
    logic signed [18:0] prod;
    logic              below_mid;
    logic signed [18:0] prod_abs;
    logic [DIV_W-1:0]   prod_mag;

    assign s_take     = s_tvalid && s_tready;
    assign count_inc  = CMP_W'(count_reg) + 1'b1;
    assign settle_end = CMP_W'(settle_reg) + CMP_W'(SAMPLES_PER_PHASE);
    assign settled    = CMP_W'(count_reg) >= CMP_W'(settle_reg);
    assign phase_end  = (s_tuser[0] == OP_SAMPLE) && (phase_reg != PH_IDLE) &&
                        settled && (count_inc >= settle_end);

    // Shared divider
    jcm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_take) state_next = phase_end ? ST_CALX_GO : ST_MAP_SETUP;
            ST_CALX_GO:   state_next = ST_CALX_WAIT;
            ST_CALX_WAIT: if (div_rsp.done) state_next = ST_CALY_GO;
            ST_CALY_GO:   state_next = ST_CALY_WAIT;
            ST_CALY_WAIT: if (div_rsp.done) state_next = ST_FINISH;
            ST_FINISH:    state_next = ST_MAP_SETUP;
            ST_MAP_SETUP: state_next = (den_cur == '0) ? ST_MAP_END : ST_MAP_GO;
            ST_MAP_GO:    state_next = ST_MAP_WAIT;
            ST_MAP_WAIT:  if (div_rsp.done) state_next = ST_MAP_END;
            ST_MAP_END:   state_next = axis_reg ? ST_DONE : ST_MAP_SETUP;
            ST_DONE:      if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and divider requests
    always_comb begin
        s_tready         = (state_reg == ST_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = DVS_W'(SAMPLES_PER_PHASE);
        case (state_reg)
            ST_CALX_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(sum_x_reg);
            end
            ST_CALY_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(sum_y_reg);
            end
            ST_MAP_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_mag;
                div_req.divisor  = den_mag_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_low_reg    <= OUT_LOW_RST;
            out_center_reg <= OUT_CENTER_RST;
            out_high_reg   <= OUT_HIGH_RST;
            settle_reg     <= SETTLE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OUT_LOW:    out_low_reg    <= cfg_data;
                CFG_OUT_CENTER: out_center_reg <= cfg_data;
                CFG_OUT_HIGH:   out_high_reg   <= cfg_data[6:0];
                CFG_SETTLE:     settle_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Phase close: new bound from the averages, swap reversed pairs on the last
    logic [7:0] xl_new, xu_new, yl_new, yu_new, xm_new, ym_new;

    always_comb begin
        xl_new = x_lower_reg;
        xu_new = x_upper_reg;
        yl_new = y_lower_reg;
        yu_new = y_upper_reg;
        xm_new = x_middle_reg;
        ym_new = y_middle_reg;
        case (phase_reg)
            PH_CENTER: begin
                xm_new = ax_reg;
                ym_new = ay_reg;
            end
            PH_TOP:    yu_new = ay_reg;
            PH_BOTTOM: yl_new = ay_reg;
            PH_RIGHT:  xu_new = ax_reg;
            default: begin
                if (x_upper_reg < ax_reg) begin
                    xl_new = x_upper_reg;
                    xu_new = ax_reg;
                end else begin
                    xl_new = ax_reg;
                end
                if (y_upper_reg < y_lower_reg) begin
                    yl_new = y_upper_reg;
                    yu_new = y_lower_reg;
                end
            end
        endcase
    end

    // Calibration state: update on acceptance, close the phase in ST_FINISH
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_lower_reg   <= BOUND_LOW_RST;
            x_middle_reg  <= BOUND_MID_RST;
            x_upper_reg   <= BOUND_HIGH_RST;
            y_lower_reg   <= BOUND_LOW_RST;
            y_middle_reg  <= BOUND_MID_RST;
            y_upper_reg   <= BOUND_HIGH_RST;
            done_flag_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
        end else if (s_take) begin
            if (s_tuser[0] == OP_START) begin
                phase_reg <= PH_CENTER;
                count_reg <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
            end else if (phase_reg != PH_IDLE) begin
                count_reg <= CNT_W'(count_inc);
                if (settled) begin
                    sum_x_reg <= sum_x_reg + SUM_W'(s_tdata[7:0]);
                    sum_y_reg <= sum_y_reg + SUM_W'(s_tdata[15:8]);
                end
            end
        end else if (state_reg == ST_FINISH) begin
            x_lower_reg  <= xl_new;
            x_upper_reg  <= xu_new;
            y_lower_reg  <= yl_new;
            y_upper_reg  <= yu_new;
            x_middle_reg <= xm_new;
            y_middle_reg <= ym_new;
            count_reg    <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            if (phase_reg == PH_LEFT) begin
                done_flag_reg <= 1'b1;
                phase_reg     <= PH_IDLE;
            end else begin
                phase_reg <= phase_t'(phase_reg + 3'd1);
            end
        end
    end

    // Mapping setup: clamp, pick the segment, form the numerator product
    always_comb begin
        smp     = axis_reg ? ys_reg       : xs_reg;
        lo_cur  = axis_reg ? y_lower_reg  : x_lower_reg;
        mid_cur = axis_reg ? y_middle_reg : x_middle_reg;
        hi_cur  = axis_reg ? y_upper_reg  : x_upper_reg;
        v_lift  = (smp < lo_cur) ? lo_cur : smp;
        v_clamp = (v_lift > hi_cur) ? hi_cur : v_lift;
        below_mid = v_clamp < mid_cur;
        if (below_mid) begin
            in_lo  = lo_cur;
            in_hi  = mid_cur;
            o_lo_w = {{2{out_low_reg[7]}}, out_low_reg};
            o_hi_w = {{2{out_center_reg[7]}}, out_center_reg};
        end else begin
            in_lo  = mid_cur;
            in_hi  = hi_cur;
            o_lo_w = {{2{out_center_reg[7]}}, out_center_reg};
            o_hi_w = {3'b000, out_high_reg};
        end
        diff    = $signed({1'b0, v_clamp}) - $signed({1'b0, in_lo});
        den_cur = $signed({1'b0, in_hi}) - $signed({1'b0, in_lo});
        span    = o_hi_w - o_lo_w;
        prod    = diff * span;
    end

    // Magnitude of the registered product for the divider
    always_comb begin
        prod_abs = prod_reg[18] ? -prod_reg : prod_reg;
        prod_mag = prod_abs[DIV_W-1:0];
    end

    // Mapping end: restore sign, add segment offset, saturate; a flat span gives the centre value
    logic signed [17:0] q_s, q_signed, r_full;
    logic [7:0]         r_sat;

    always_comb begin
        q_s      = $signed({2'b00, div_rsp.quotient});
        q_signed = neg_reg ? -q_s : q_s;
        r_full   = q_signed + $signed({{10{o_lo_reg[7]}}, o_lo_reg});
        if (zero_reg)
            r_sat = out_center_reg;
        else if (r_full < -18'sd128)
            r_sat = 8'h80;
        else if (r_full > 18'sd127)
            r_sat = 8'h7F;
        else
            r_sat = r_full[7:0];
    end

    // Working registers of the sequencer
    always_ff @(posedge aclk) begin
        if (s_take) begin
            xs_reg   <= s_tdata[7:0];
            ys_reg   <= s_tdata[15:8];
            axis_reg <= 1'b0;
        end
        if (state_reg == ST_CALX_WAIT && div_rsp.done)
            ax_reg <= div_rsp.quotient[7:0];
        if (state_reg == ST_CALY_WAIT && div_rsp.done)
            ay_reg <= div_rsp.quotient[7:0];
        if (state_reg == ST_MAP_SETUP) begin
            prod_reg    <= prod;
            den_mag_reg <= DVS_W'(den_cur[8] ? -den_cur : den_cur);
            neg_reg     <= prod[18] ^ den_cur[8];
            zero_reg    <= (den_cur == '0);
            o_lo_reg    <= o_lo_w[7:0];
        end
        if (state_reg == ST_MAP_END) begin
            if (axis_reg) y_pos_reg <= r_sat;
            else          x_pos_reg <= r_sat;
            axis_reg <= 1'b1;
        end
    end

    // Result register: load when free or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
            m_data_reg <= {4'b0000, phase_reg, done_flag_reg, y_pos_reg, x_pos_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A request is taken only when the divider is free
    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |-> !div_rsp.busy)
        else $error("request accepted while the divider is busy");

    // After a request the sequencer is busy for at least the next cycle
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |=> !s_tready)
        else $error("sequencer ready again straight after a request");

    // The calibrated flag rises only when the left phase closes
    a_flag_on_left: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_flag_reg) |-> $past(phase_reg) == PH_LEFT && phase_reg == PH_IDLE)
        else $error("calibrated flag set outside the close of the left phase");

    // Divider results arrive only while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_CALX_WAIT || state_reg == ST_CALY_WAIT ||
                         state_reg == ST_MAP_WAIT)
        else $error("divider result arrived outside a wait state");

endmodule
